// ===== rtl/rds_pkg.sv =====
// Shared types, constants and saturation helpers for the stencil step engine.
package rds_pkg;

	localparam int GRID_SIZE = 256;
	localparam int FRAC_BITS = 28;
	localparam int IDX_W     = $clog2(GRID_SIZE);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int CELLS     = GRID_SIZE * GRID_SIZE;
	localparam int DATA_W    = 32;
	localparam int REG_W     = 31;
	localparam int WIDE_W    = 2 * DATA_W - FRAC_BITS;
	localparam int CNT_W     = 17;
	localparam int INTERIOR  = (GRID_SIZE - 2) * (GRID_SIZE - 2);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_SWEEP = 1'b1;

	localparam logic [2:0] REG_TIME_STEP  = 3'd0;
	localparam logic [2:0] REG_DECAY_RATE = 3'd1;
	localparam logic [2:0] REG_COEF_X     = 3'd2;
	localparam logic [2:0] REG_COEF_Y     = 3'd3;
	localparam logic [2:0] REG_LOW_THRESH = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
	} cell_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		cell_t             wdata;
	} grid_req_t;

	function automatic logic signed [WIDE_W-1:0] sx(input logic signed [DATA_W-1:0] v);
		return WIDE_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-DATA_W:0] top;
		top = v[WIDE_W-1:DATA_W-1];
		if (~|top || &top) return v[DATA_W-1:0];
		else if (v[WIDE_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
		else return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage

// ===== rtl/rds_mul.sv =====
// Shared fixed-point multiplier: product, round half up, shift, saturate.
module rds_mul import rds_pkg::*; (
	input  logic                     clk,
	input  logic signed [DATA_W-1:0] x,
	input  logic signed [DATA_W-1:0] y,
	output logic signed [DATA_W-1:0] res_s2
);

	logic signed [2*DATA_W-1:0] prod_s1;
	logic signed [2*DATA_W-1:0] rnd;

	assign rnd = prod_s1 + (2*DATA_W)'(64'sd1 <<< (FRAC_BITS - 1));

	always_ff @(posedge clk) begin
		prod_s1 <= x * y;
		res_s2  <= sat_wide(rnd[2*DATA_W-1:FRAC_BITS]);
	end

endmodule

// ===== rtl/rds_grid.sv =====
// Three concentration grids sharing one address, registered read.
module rds_grid import rds_pkg::*; (
	input  logic      clk,
	input  grid_req_t req,
	output cell_t     rdata
);

	logic [DATA_W-1:0] mem_a [CELLS];
	logic [DATA_W-1:0] mem_b [CELLS];
	logic [DATA_W-1:0] mem_c [CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_a[req.addr] <= req.wdata.a;
			mem_b[req.addr] <= req.wdata.b;
			mem_c[req.addr] <= req.wdata.c;
		end
		rdata.a <= mem_a[req.addr];
		rdata.b <= mem_b[req.addr];
		rdata.c <= mem_c[req.addr];
	end

endmodule

// ===== rtl/reaction_diffusion_stencil_step.sv =====
// Stencil step engine top level: command sequencer, line buffer, count.
// A write word passes through ST_WRITE; a read word through ST_RADDR and ST_RDATA, paced by the grid read port.
// Sweep: each interior cell takes 5 grid reads, 7 passes through the shared
// multiplier and 1 write.
// One word is taken at a time; a new word waits until any pending result is taken.
// arst_n clears control and sets configuration to its defaults; grid contents are undefined until written.
module reaction_diffusion_stencil_step import rds_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [111:0]  s_tdata,   // row, col, in_a, in_b, in_c
	input  logic [1:0]    s_tuser,   // operation
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [119:0]  m_tdata,   // out_a, out_b, out_c, low_count, zero pad
	output logic          m_tuser,   // result_kind
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_WRITE = 8'b0000_0010,
		ST_RADDR = 8'b0000_0100,
		ST_RDATA = 8'b0000_1000,
		ST_FETCH = 8'b0001_0000,
		ST_CALC  = 8'b0010_0000,
		ST_STORE = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		FP_CTR, FP_UP, FP_DN, FP_LF, FP_RT, FP_END
	} fetch_t;

	typedef enum logic [2:0] {
		MS_AB, MS_KC, MS_NA, MS_NB1, MS_NBX, MS_NBY, MS_NC
	} mstep_t;

	state_t state_q;
	fetch_t fph_q;
	mstep_t mstep_q;
	logic [1:0] mcnt_q;

	logic [REG_W-1:0] dt_q, kap_q, cx_q, cy_q, thr_q;

	logic [IDX_W-1:0]  row_q, col_q;
	cell_t             wr_q;
	logic [CNT_W-1:0]  count_q;

	logic signed [DATA_W-1:0] a_q, b_q, c_q, up_q, dn_q, lf_q, rt_q, prevb_q;
	logic signed [DATA_W-1:0] ab_q, kc_q, mna_q, m1_q, m2_q, m3_q, m4_q;
	logic signed [DATA_W-1:0] lx_q, ly_q, t1_q, t2_q;
	logic signed [DATA_W-1:0] na, nb, nc;

	logic [DATA_W-1:0] line_mem [GRID_SIZE];
	logic [DATA_W-1:0] lb_q;

	logic                     mtvalid_q, mkind_q;
	cell_t                    mcell_q;
	logic [CNT_W-1:0]         mcount_q;

	grid_req_t req;
	cell_t     rd;
	logic signed [DATA_W-1:0] mx, my, mres;

	logic accept;

	rds_grid u_grid (.clk(clk), .req(req), .rdata(rd));
	rds_mul  u_mul  (.clk(clk), .x(mx), .y(my), .res_s2(mres));

	assign s_tready  = (state_q == ST_IDLE) && !mtvalid_q;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mtvalid_q;
	assign m_tuser   = mkind_q;
	assign m_tdata   = {7'd0, mcount_q, mcell_q.c, mcell_q.b, mcell_q.a};

	assign na = sat_wide(sx(a_q) - sx(mna_q));
	assign nb = sat_wide(sx(b_q) + sx(m1_q) + sx(m2_q) + sx(m3_q));
	assign nc = sat_wide(sx(c_q) + sx(m4_q));

	always_comb begin
		req.we    = 1'b0;
		req.addr  = {row_q, col_q};
		req.wdata = wr_q;
		case (state_q)
			ST_WRITE: req.we = 1'b1;
			ST_FETCH: begin
				case (fph_q)
					FP_UP:   req.addr = {row_q - IDX_W'(1), col_q};
					FP_DN:   req.addr = {row_q + IDX_W'(1), col_q};
					FP_LF:   req.addr = {row_q, col_q - IDX_W'(1)};
					FP_RT:   req.addr = {row_q, col_q + IDX_W'(1)};
					default: req.addr = {row_q, col_q};
				endcase
			end
			ST_STORE: begin
				req.we    = 1'b1;
				req.wdata = '{a: na, b: nb, c: nc};
			end
			default: ;
		endcase
	end

	always_comb begin
		case (mstep_q)
			MS_AB:   begin mx = a_q;                 my = b_q;  end
			MS_KC:   begin mx = {1'b0, kap_q};       my = c_q;  end
			MS_NA:   begin mx = {1'b0, dt_q};        my = ab_q; end
			MS_NB1:  begin mx = {1'b0, dt_q};        my = t1_q; end
			MS_NBX:  begin mx = {1'b0, cx_q};        my = lx_q; end
			MS_NBY:  begin mx = {1'b0, cy_q};        my = ly_q; end
			MS_NC:   begin mx = {1'b0, dt_q};        my = t2_q; end
			default: begin mx = a_q;                 my = b_q;  end
		endcase
	end

	always_ff @(posedge clk) begin
		lb_q <= line_mem[col_q];
		if (state_q == ST_STORE) line_mem[col_q] <= b_q;
		lx_q <= sat_wide(sx(dn_q) - (sx(b_q) <<< 1) + sx(up_q));
		ly_q <= sat_wide(sx(rt_q) - (sx(b_q) <<< 1) + sx(lf_q));
		t1_q <= sat_wide(sx(kc_q) - (sx(ab_q) <<< 1));
		t2_q <= sat_wide(sx(ab_q) + (sx(ab_q) <<< 1) - sx(kc_q));
		if (accept) begin
			wr_q  <= '{a: s_tdata[47:16], b: s_tdata[79:48], c: s_tdata[111:80]};
			if (s_tuser == OP_SWEEP) begin
				row_q <= IDX_W'(1);
				col_q <= IDX_W'(1);
			end else begin
				row_q <= s_tdata[7:0];
				col_q <= s_tdata[15:8];
			end
		end
		case (state_q)
			ST_FETCH: begin
				case (fph_q)
					FP_UP: begin
						a_q <= rd.a;
						b_q <= rd.b;
						c_q <= rd.c;
					end
					FP_DN: up_q <= (row_q == IDX_W'(1)) ? rd.b : lb_q;
					FP_LF: dn_q <= rd.b;
					FP_RT: lf_q <= (col_q == IDX_W'(1)) ? rd.b : prevb_q;
					FP_END: rt_q <= rd.b;
					default: ;
				endcase
			end
			ST_CALC: begin
				if (mcnt_q == 2'd2) begin
					case (mstep_q)
						MS_AB:   ab_q  <= mres;
						MS_KC:   kc_q  <= mres;
						MS_NA:   mna_q <= mres;
						MS_NB1:  m1_q  <= mres;
						MS_NBX:  m2_q  <= mres;
						MS_NBY:  m3_q  <= mres;
						MS_NC:   m4_q  <= mres;
						default: ;
					endcase
				end
			end
			ST_STORE: begin
				prevb_q <= b_q;
				if (col_q == IDX_W'(GRID_SIZE - 2)) begin
					col_q <= IDX_W'(1);
					row_q <= row_q + IDX_W'(1);
				end else begin
					col_q <= col_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fph_q     <= FP_CTR;
			mstep_q   <= MS_AB;
			mcnt_q    <= 2'd0;
			count_q   <= '0;
			mtvalid_q <= 1'b0;
			mkind_q   <= KIND_READ;
			mcell_q   <= '0;
			mcount_q  <= '0;
			dt_q      <= REG_W'(2440322);
			kap_q     <= REG_W'(6710886);
			cx_q      <= REG_W'(44078310);
			cy_q      <= REG_W'(44078310);
			thr_q     <= REG_W'(13421773);
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_TIME_STEP:  dt_q  <= cfg_data[REG_W-1:0];
					REG_DECAY_RATE: kap_q <= cfg_data[REG_W-1:0];
					REG_COEF_X:     cx_q  <= cfg_data[REG_W-1:0];
					REG_COEF_Y:     cy_q  <= cfg_data[REG_W-1:0];
					REG_LOW_THRESH: thr_q <= cfg_data[REG_W-1:0];
					default: ;
				endcase
			end
			if (mtvalid_q && m_tready) mtvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							OP_WRITE: state_q <= ST_WRITE;
							OP_READ:  state_q <= ST_RADDR;
							OP_SWEEP: begin
								state_q <= ST_FETCH;
								fph_q   <= FP_CTR;
								count_q <= '0;
							end
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_RADDR: state_q <= ST_RDATA;
				ST_RDATA: begin
					mtvalid_q <= 1'b1;
					mkind_q   <= KIND_READ;
					mcell_q   <= rd;
					mcount_q  <= '0;
					state_q   <= ST_IDLE;
				end
				ST_FETCH: begin
					if (fph_q == FP_END) begin
						state_q <= ST_CALC;
						mstep_q <= MS_AB;
						mcnt_q  <= 2'd0;
					end else begin
						fph_q <= fetch_t'(fph_q + 3'd1);
					end
				end
				ST_CALC: begin
					if (mcnt_q == 2'd2) begin
						mcnt_q <= 2'd0;
						if (mstep_q == MS_NC) state_q <= ST_STORE;
						else mstep_q <= mstep_t'(mstep_q + 3'd1);
					end else begin
						mcnt_q <= mcnt_q + 2'd1;
					end
				end
				ST_STORE: begin
					if (na < $signed({1'b0, thr_q}) && count_q != {CNT_W{1'b1}})
						count_q <= count_q + CNT_W'(1);
					fph_q <= FP_CTR;
					if (row_q == IDX_W'(GRID_SIZE - 2) && col_q == IDX_W'(GRID_SIZE - 2))
						state_q <= ST_DONE;
					else
						state_q <= ST_FETCH;
				end
				ST_DONE: begin
					mtvalid_q <= 1'b1;
					mkind_q   <= KIND_SWEEP;
					mcell_q   <= '0;
					mcount_q  <= count_q;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_sweep_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_CALC || state_q == ST_STORE) |->
		(row_q != '0 && col_q != '0 && row_q <= IDX_W'(GRID_SIZE - 2) &&
		 col_q <= IDX_W'(GRID_SIZE - 2)))
		else $error("sweep left the interior");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_SWEEP) |-> (m_tdata[112:96] <= CNT_W'(INTERIOR)))
		else $error("low count above interior cell count");

	a_read_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_READ) |-> (m_tdata[112:96] == '0))
		else $error("read result carries a count");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("word taken while busy");

endmodule

// ===== dv/rds_checker.sv =====
`timescale 1ns / 100ps
// Checker for the stencil step engine: tracks grids and registers, predicts and compares results.
module rds_checker import rds_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,   // row, col, in_a, in_b, in_c
	input  logic [1:0]   s_tuser,   // operation
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [119:0] m_tdata,   // out_a, out_b, out_c, low_count, zero pad
	input  logic         m_tuser,   // result_kind
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           errors,
	output int           outstanding
);

	localparam logic [30:0] RST_TIME_STEP  = 31'd2440322;
	localparam logic [30:0] RST_DECAY_RATE = 31'd6710886;
	localparam logic [30:0] RST_COEF       = 31'd44078310;
	localparam logic [30:0] RST_LOW_THRESH = 31'd13421773;
	localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;

	typedef struct {
		logic                     kind;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] c;
		logic [CNT_W-1:0]         cnt;
	} result_t;

	result_t result_q[$];

	logic signed [DATA_W-1:0] conc_a[CELLS];
	logic signed [DATA_W-1:0] conc_b[CELLS];
	logic signed [DATA_W-1:0] conc_c[CELLS];
	logic signed [DATA_W-1:0] old_a[CELLS];
	logic signed [DATA_W-1:0] old_b[CELLS];
	logic signed [DATA_W-1:0] old_c[CELLS];

	logic [REG_W-1:0] dt, kappa, cx, cy, thresh;

	initial errors = 0;
	initial outstanding = 0;

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// product scaled back by the fraction bits, rounded half up
	function automatic longint fxmul(longint x, longint y);
		longint p;
		p = x * y + (64'sd1 <<< (FRAC_BITS - 1));
		return sat(p >>> FRAC_BITS);
	endfunction

	function automatic logic [CNT_W-1:0] step_grids();
		longint a, b, cc, ab, kc, lx, ly, na, nb, nc;
		longint d, k, kx, ky, th;
		int i;
		logic [CNT_W-1:0] cnt;
		cnt = '0;
		d = dt;
		k = kappa;
		kx = cx;
		ky = cy;
		th = thresh;
		old_a = conc_a;
		old_b = conc_b;
		old_c = conc_c;
		for (int r = 1; r < GRID_SIZE - 1; r++) begin
			for (int c = 1; c < GRID_SIZE - 1; c++) begin
				i = r * GRID_SIZE + c;
				a = old_a[i];
				b = old_b[i];
				cc = old_c[i];
				ab = fxmul(a, b);
				kc = fxmul(k, cc);
				lx = sat(longint'(old_b[i + GRID_SIZE]) - 2 * b + longint'(old_b[i - GRID_SIZE]));
				ly = sat(longint'(old_b[i + 1]) - 2 * b + longint'(old_b[i - 1]));
				na = sat(a - fxmul(d, ab));
				nb = sat(b + fxmul(d, sat(kc - 2 * ab)) + fxmul(kx, lx) + fxmul(ky, ly));
				nc = sat(cc + fxmul(d, sat(3 * ab - kc)));
				conc_a[i] = na[31:0];
				conc_b[i] = nb[31:0];
				conc_c[i] = nc[31:0];
				if (na < th && cnt != COUNT_MAX) cnt++;
			end
		end
		return cnt;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t r;
		int idx;
		if (!arst_n) begin
			dt <= RST_TIME_STEP;
			kappa <= RST_DECAY_RATE;
			cx <= RST_COEF;
			cy <= RST_COEF;
			thresh <= RST_LOW_THRESH;
			result_q.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					errors++;
				end else begin
					r = result_q.pop_front();
					if (m_tuser !== r.kind) report_mismatch("result_kind", m_tuser, r.kind);
					if ($signed(m_tdata[31:0]) !== r.a)
						report_mismatch("out_a", $signed(m_tdata[31:0]), r.a);
					if ($signed(m_tdata[63:32]) !== r.b)
						report_mismatch("out_b", $signed(m_tdata[63:32]), r.b);
					if ($signed(m_tdata[95:64]) !== r.c)
						report_mismatch("out_c", $signed(m_tdata[95:64]), r.c);
					if (m_tdata[112:96] !== r.cnt)
						report_mismatch("low_count", m_tdata[112:96], r.cnt);
				end
			end
			if (s_tvalid && s_tready) begin
				idx = {s_tdata[7:0], s_tdata[15:8]};
				case (s_tuser)
					OP_WRITE: begin
						conc_a[idx] = s_tdata[47:16];
						conc_b[idx] = s_tdata[79:48];
						conc_c[idx] = s_tdata[111:80];
					end
					OP_READ: begin
						r.kind = KIND_READ;
						r.a = conc_a[idx];
						r.b = conc_b[idx];
						r.c = conc_c[idx];
						r.cnt = '0;
						result_q.push_back(r);
					end
					OP_SWEEP: begin
						r.kind = KIND_SWEEP;
						r.a = '0;
						r.b = '0;
						r.c = '0;
						r.cnt = step_grids();
						result_q.push_back(r);
					end
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIME_STEP:  dt <= cfg_data[30:0];
					REG_DECAY_RATE: kappa <= cfg_data[30:0];
					REG_COEF_X:     cx <= cfg_data[30:0];
					REG_COEF_Y:     cy <= cfg_data[30:0];
					REG_LOW_THRESH: thresh <= cfg_data[30:0];
					default: ;
				endcase
			end
			outstanding = result_q.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench top: stimulus, idling phases and verdict for the stencil step engine.
module testbench import rds_pkg::*;;

	localparam logic [1:0] OP_NONE   = 2'd3;
	localparam logic [2:0] REG_NONE  = 3'd7;
	localparam longint     MAX_CYCLES = 20_000_000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = OP_WRITE;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic         m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	int     errors;
	int     outstanding;
	int     gap_pct = 0;
	int     stall_pct = 0;
	bit     hold_go = 0;
	bit     hold_on = 0;
	longint cycles = 0;

	always #5 clk = ~clk;

	reaction_diffusion_stencil_step DUT (.*);

	rds_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= !hold_on && ($urandom_range(99) >= stall_pct);

	// long receiver hold-off while reads keep coming
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (300) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic send_word(logic [1:0] op, logic [7:0] row, logic [7:0] col,
	                         logic [31:0] a, logic [31:0] b, logic [31:0] c);
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {c, b, a, col, row};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_site(logic [7:0] row, logic [7:0] col,
	                          logic [31:0] a, logic [31:0] b, logic [31:0] c);
		send_word(OP_WRITE, row, col, a, b, c);
	endtask

	task automatic read_site(logic [7:0] row, logic [7:0] col);
		send_word(OP_READ, row, col, $urandom, $urandom, $urandom);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] d, logic [31:0] k, logic [31:0] x,
	                        logic [31:0] y, logic [31:0] th);
		settle();
		write_reg(REG_TIME_STEP, d);
		write_reg(REG_DECAY_RATE, k);
		write_reg(REG_COEF_X, x);
		write_reg(REG_COEF_Y, y);
		write_reg(REG_LOW_THRESH, th);
	endtask

	function automatic logic [31:0] moderate();
		if ($urandom_range(63) == 0) return $urandom;
		return $signed($urandom) >>> 3;
	endfunction

	task automatic random_words(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				write_site(8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
			else if (pick < 90)
				read_site(8'($urandom), 8'($urandom));
			else
				send_word(OP_NONE, 8'($urandom), 8'($urandom), $urandom, $urandom,
				          $urandom);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_NONE, 32'hFFFF_FFFF);
		set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// corners with extreme values, read back, unused opcode
		write_site(8'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		write_site(8'd255, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		write_site(8'd0, 8'd255, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
		write_site(8'd255, 8'd0, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		read_site(8'd0, 8'd0);
		read_site(8'd255, 8'd255);
		read_site(8'd0, 8'd255);
		read_site(8'd255, 8'd0);
		send_word(OP_NONE, 8'd17, 8'd99, 32'h1234_5678, 32'h0, 32'h0);
		read_site(8'd255, 8'd0);

		// load the whole grid
		for (int r = 0; r < GRID_SIZE; r++)
			for (int c = 0; c < GRID_SIZE; c++)
				write_site(8'(r), 8'(c), moderate(), moderate(), moderate());

		set_regs(32'd2440322, 32'd6710886, 32'd44078310, 32'd22039155, 32'd134217728);
		stall_pct = 74;
		send_word(OP_SWEEP, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0);
		read_site(8'd1, 8'd1);
		read_site(8'd254, 8'd254);
		read_site(8'd0, 8'd128);

		// receiver held off: block fills and stalls its input
		hold_go = 1;
		for (int i = 0; i < 8; i++) read_site(8'($urandom), 8'($urandom));

		// saturating step at the top of every register
		set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(OP_SWEEP, 8'd3, 8'd3, 32'h0, 32'h0, 32'h0);
		read_site(8'd2, 8'd2);
		read_site(8'd128, 8'd7);

		set_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		gap_pct = 0;
		stall_pct = 0;
		random_words(25);
		set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
		gap_pct = 74;
		stall_pct = 0;
		random_words(25);
		gap_pct = 0;
		stall_pct = 74;
		random_words(25);
		gap_pct = 38;
		stall_pct = 38;
		random_words(25);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
